// ----- rtl/tun_pkg.sv -----
// shared widths, constants and transaction types for the triangle unit normal block
package tun_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned NORM_WIDTH  = 32;

  localparam int unsigned EDGE_WIDTH  = COORD_WIDTH + 1;
  localparam int unsigned PROD_WIDTH  = 2 * EDGE_WIDTH;
  localparam int unsigned CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int unsigned LEN_WIDTH   = $clog2(CROSS_WIDTH + 1);

  // block normalisation puts the largest magnitude at bit 30 or 31
  localparam int unsigned MAG_FRAC    = 31;
  localparam int unsigned MAG_WIDTH   = MAG_FRAC + 1;
  localparam int unsigned EXT_WIDTH   = CROSS_WIDTH + MAG_FRAC;

  localparam int unsigned SUM_WIDTH   = 2 * MAG_WIDTH;
  localparam int unsigned ROOT_WIDTH  = SUM_WIDTH / 2;
  localparam int unsigned SREM_WIDTH  = ROOT_WIDTH + 2;
  localparam int unsigned RND_WIDTH   = ROOT_WIDTH + 1;

  // one equals 2^NORM_FRAC at the output
  localparam int unsigned NORM_FRAC   = NORM_WIDTH - 2;
  localparam int unsigned QUO_WIDTH   = NORM_WIDTH + 1;
  localparam int unsigned NUM_WIDTH   = MAG_WIDTH + NORM_FRAC + 1;
  localparam int unsigned DREM_WIDTH  = RND_WIDTH + 1;
  localparam int unsigned DIV_WIDTH   = DREM_WIDTH + QUO_WIDTH;

  localparam logic [QUO_WIDTH-1:0] NORM_MAX = QUO_WIDTH'((64'd1 << (NORM_WIDTH - 1)) - 64'd1);

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p0_z;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [NORM_WIDTH-1:0] norm_x;
    logic signed [NORM_WIDTH-1:0] norm_y;
    logic signed [NORM_WIDTH-1:0] norm_z;
    logic                         degenerate;
  } tri_out_t;

  // classified item between front and back
  typedef struct packed {
    logic [2:0][MAG_WIDTH-1:0] mag;
    logic [2:0]                neg;
    logic                      degen;
  } mid_t;

endpackage

// ----- rtl/tun_front.sv -----
// front end: edge vectors, exact cross product, block normalisation and degenerate check
module tun_front import tun_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  tri_in_t in_data_i,
  output logic    q_valid_o,
  input  logic    q_ready_i,
  output mid_t    q_data_o
);

  logic [4:0] v_q, v_d;
  logic       en;

  logic signed [EDGE_WIDTH-1:0] a_q [3];
  logic signed [EDGE_WIDTH-1:0] b_q [3];
  logic signed [EDGE_WIDTH-1:0] a_d [3];
  logic signed [EDGE_WIDTH-1:0] b_d [3];
  logic signed [PROD_WIDTH-1:0] pp_q [3];
  logic signed [PROD_WIDTH-1:0] pn_q [3];
  logic signed [PROD_WIDTH-1:0] pp_d [3];
  logic signed [PROD_WIDTH-1:0] pn_d [3];
  logic [2:0][CROSS_WIDTH-1:0]  mag2_q, mag2_d, mag3_q;
  logic [2:0]                   neg2_q, neg2_d, neg3_q;
  logic [LEN_WIDTH-1:0]         len_q, len_d;
  mid_t                         out_q, out_d;

  assign en         = !v_q[4] || q_ready_i;
  assign in_ready_o = en;
  assign q_valid_o  = v_q[4];
  assign q_data_o   = out_q;
  assign v_d        = {v_q[3:0], in_valid_i};

  function automatic logic signed [EDGE_WIDTH-1:0] edge_sub(
    logic signed [COORD_WIDTH-1:0] p, logic signed [COORD_WIDTH-1:0] o);
    return {p[COORD_WIDTH-1], p} - {o[COORD_WIDTH-1], o};
  endfunction

  always_comb begin
    a_d[0] = edge_sub(in_data_i.p1_x, in_data_i.p0_x);
    a_d[1] = edge_sub(in_data_i.p1_y, in_data_i.p0_y);
    a_d[2] = edge_sub(in_data_i.p1_z, in_data_i.p0_z);
    b_d[0] = edge_sub(in_data_i.p2_x, in_data_i.p0_x);
    b_d[1] = edge_sub(in_data_i.p2_y, in_data_i.p0_y);
    b_d[2] = edge_sub(in_data_i.p2_z, in_data_i.p0_z);
  end

  // n = a x b, each term kept as two products
  always_comb begin
    pp_d[0] = a_q[1] * b_q[2];
    pn_d[0] = a_q[2] * b_q[1];
    pp_d[1] = a_q[2] * b_q[0];
    pn_d[1] = a_q[0] * b_q[2];
    pp_d[2] = a_q[0] * b_q[1];
    pn_d[2] = a_q[1] * b_q[0];
  end

  always_comb begin
    logic signed [CROSS_WIDTH-1:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = {pp_q[i][PROD_WIDTH-1], pp_q[i]} - {pn_q[i][PROD_WIDTH-1], pn_q[i]};
      neg2_d[i] = diff[CROSS_WIDTH-1];
      mag2_d[i] = diff[CROSS_WIDTH-1] ? CROSS_WIDTH'(-diff) : CROSS_WIDTH'(diff);
    end
  end

  // bit length of the largest magnitude
  always_comb begin
    logic [CROSS_WIDTH-1:0] any;
    any   = mag2_q[0] | mag2_q[1] | mag2_q[2];
    len_d = '0;
    for (int j = 0; j < CROSS_WIDTH; j++) begin
      if (any[j]) len_d = LEN_WIDTH'(j + 1);
    end
  end

  // shift so the top bit lands at MAG_FRAC, then halve it to bit MAG_FRAC - 1, rounding half up when bits drop off
  always_comb begin
    logic [EXT_WIDTH-1:0] ext;
    logic [EXT_WIDTH-1:0] t;
    logic [LEN_WIDTH-1:0] lm1;
    lm1 = len_q - LEN_WIDTH'(1);
    for (int i = 0; i < 3; i++) begin
      ext = {mag3_q[i], MAG_FRAC'(0)};
      t   = ext >> lm1;
      out_d.mag[i] = MAG_WIDTH'(t >> 1) + MAG_WIDTH'(t[0]);
    end
    out_d.neg   = neg3_q;
    out_d.degen = (len_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q    <= a_d;
      b_q    <= b_d;
      pp_q   <= pp_d;
      pn_q   <= pn_d;
      mag2_q <= mag2_d;
      neg2_q <= neg2_d;
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      len_q  <= len_d;
      out_q  <= out_d;
    end
  end

endmodule

// ----- rtl/tun_queue.sv -----
// short queue between front and back so each side stalls on its own
module tun_queue import tun_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  mid_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output mid_t pop_data_o
);

  localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

  mid_t                mem_q [QUEUE_DEPTH];
  logic [PtrWidth-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntWidth'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) wptr_d = (wptr_q == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PtrWidth'(1);
    if (pop)  rptr_d = (rptr_q == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PtrWidth'(1);
    if (push && !pop) cnt_d = cnt_q + CntWidth'(1);
    if (pop && !push) cnt_d = cnt_q - CntWidth'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// ----- rtl/tun_back.sv -----
// back end: sum of squares, pipelined rounded square root and three pipelined dividers
module tun_back import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  output logic     q_ready_o,
  input  mid_t     q_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tri_out_t out_data_o
);

  localparam int unsigned SqrtStages = ROOT_WIDTH;
  localparam int unsigned DivStages  = QUO_WIDTH;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } sgn_t;

  logic en;

  // squares and sum
  logic                       b0_v_q, b1_v_q;
  mid_t                       b0_it_q, b1_it_q;
  logic [2:0][SUM_WIDTH-1:0]  sq_d, sq_q;
  logic [SUM_WIDTH-1:0]       sum_d, sum_q;

  // square root, one result bit per stage
  logic                       sr_v_q   [SqrtStages];
  mid_t                       sr_it_q  [SqrtStages];
  logic [SREM_WIDTH-1:0]      sr_rem_q [SqrtStages];
  logic [SREM_WIDTH-1:0]      sr_rem_d [SqrtStages];
  logic [ROOT_WIDTH-1:0]      sr_rt_q  [SqrtStages];
  logic [ROOT_WIDTH-1:0]      sr_rt_d  [SqrtStages];
  logic [SUM_WIDTH-1:0]       sr_sv_q  [SqrtStages];
  logic [SUM_WIDTH-1:0]       sr_sv_d  [SqrtStages];

  // rounding and numerator set-up
  logic                       rn_v_q, nm_v_q;
  mid_t                       rn_it_q;
  sgn_t                       nm_sg_q;
  logic [RND_WIDTH-1:0]       rn_r_d, rn_r_q, nm_r_q;
  logic [2:0][DIV_WIDTH-1:0]  nm_dv_d, nm_dv_q;

  // division, one quotient bit per stage
  logic                       dv_v_q  [DivStages];
  sgn_t                       dv_sg_q [DivStages];
  logic [RND_WIDTH-1:0]       dv_r_q  [DivStages];
  logic [2:0][DIV_WIDTH-1:0]  dv_x_q  [DivStages];
  logic [2:0][DIV_WIDTH-1:0]  dv_x_d  [DivStages];

  tri_out_t                   out_q, out_d;
  logic                       out_v_q;

  assign en          = !out_v_q || out_ready_i;
  assign q_ready_o   = en;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = q_data_i.mag[i] * q_data_i.mag[i];
    end
    sum_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_comb begin
    logic [SREM_WIDTH-1:0] prem, remx, trial;
    logic [ROOT_WIDTH-1:0] prt;
    logic [SUM_WIDTH-1:0]  psv;
    for (int j = 0; j < SqrtStages; j++) begin
      if (j == 0) begin
        prem = '0;
        prt  = '0;
        psv  = sum_q;
      end else begin
        prem = sr_rem_q[(j == 0) ? 0 : j - 1];
        prt  = sr_rt_q[(j == 0) ? 0 : j - 1];
        psv  = sr_sv_q[(j == 0) ? 0 : j - 1];
      end
      remx  = {prem[SREM_WIDTH-3:0], psv[SUM_WIDTH-1 -: 2]};
      trial = {prt, 2'b01};
      if (remx >= trial) begin
        sr_rem_d[j] = remx - trial;
        sr_rt_d[j]  = {prt[ROOT_WIDTH-2:0], 1'b1};
      end else begin
        sr_rem_d[j] = remx;
        sr_rt_d[j]  = {prt[ROOT_WIDTH-2:0], 1'b0};
      end
      sr_sv_d[j] = psv << 2;
    end
  end

  // round to nearest: one up when the remainder exceeds the floor root
  always_comb begin
    logic [ROOT_WIDTH-1:0] rt;
    logic [SREM_WIDTH-1:0] rm;
    rt     = sr_rt_q[SqrtStages-1];
    rm     = sr_rem_q[SqrtStages-1];
    rn_r_d = {1'b0, rt} + RND_WIDTH'(rm > {2'b00, rt});
    for (int i = 0; i < 3; i++) begin
      nm_dv_d[i] = DIV_WIDTH'({rn_it_q.mag[i], NORM_FRAC'(0)})
                 + DIV_WIDTH'(rn_r_q >> 1);
    end
  end

  always_comb begin
    logic [DIV_WIDTH-1:0]  px, x;
    logic [DREM_WIDTH-1:0] hi;
    logic [RND_WIDTH-1:0]  r;
    for (int k = 0; k < DivStages; k++) begin
      r = (k == 0) ? nm_r_q : dv_r_q[(k == 0) ? 0 : k - 1];
      for (int i = 0; i < 3; i++) begin
        px = (k == 0) ? nm_dv_q[i] : dv_x_q[(k == 0) ? 0 : k - 1][i];
        x  = px << 1;
        hi = x[DIV_WIDTH-1:QUO_WIDTH];
        if (hi >= {1'b0, r}) begin
          hi   = hi - {1'b0, r};
          x[0] = 1'b1;
        end
        dv_x_d[k][i] = {hi, x[QUO_WIDTH-1:0]};
      end
    end
  end

  always_comb begin
    logic [QUO_WIDTH-1:0]  q;
    logic [NORM_WIDTH-1:0] c [3];
    sgn_t                  sg;
    sg = dv_sg_q[DivStages-1];
    for (int i = 0; i < 3; i++) begin
      q = dv_x_q[DivStages-1][i][QUO_WIDTH-1:0];
      if (q > NORM_MAX) q = NORM_MAX;
      c[i] = sg.neg[i] ? NORM_WIDTH'(-q) : NORM_WIDTH'(q);
      if (sg.degen) c[i] = '0;
    end
    out_d.norm_x     = c[0];
    out_d.norm_y     = c[1];
    out_d.norm_z     = c[2];
    out_d.degenerate = sg.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q  <= 1'b0;
      b1_v_q  <= 1'b0;
      rn_v_q  <= 1'b0;
      nm_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j < SqrtStages; j++) sr_v_q[j] <= 1'b0;
      for (int k = 0; k < DivStages; k++)  dv_v_q[k] <= 1'b0;
    end else if (en) begin
      b0_v_q <= q_valid_i;
      b1_v_q <= b0_v_q;
      sr_v_q[0] <= b1_v_q;
      for (int j = 1; j < SqrtStages; j++) sr_v_q[j] <= sr_v_q[j-1];
      rn_v_q <= sr_v_q[SqrtStages-1];
      nm_v_q <= rn_v_q;
      dv_v_q[0] <= nm_v_q;
      for (int k = 1; k < DivStages; k++) dv_v_q[k] <= dv_v_q[k-1];
      out_v_q <= dv_v_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_it_q <= q_data_i;
      sq_q    <= sq_d;
      b1_it_q <= b0_it_q;
      sum_q   <= sum_d;
      sr_it_q[0] <= b1_it_q;
      for (int j = 1; j < SqrtStages; j++) sr_it_q[j] <= sr_it_q[j-1];
      sr_rem_q <= sr_rem_d;
      sr_rt_q  <= sr_rt_d;
      sr_sv_q  <= sr_sv_d;
      rn_it_q  <= sr_it_q[SqrtStages-1];
      rn_r_q   <= rn_r_d;
      nm_sg_q  <= '{neg: rn_it_q.neg, degen: rn_it_q.degen};
      nm_r_q   <= rn_r_q;
      nm_dv_q  <= nm_dv_d;
      dv_sg_q[0] <= nm_sg_q;
      dv_r_q[0]  <= nm_r_q;
      for (int k = 1; k < DivStages; k++) begin
        dv_sg_q[k] <= dv_sg_q[k-1];
        dv_r_q[k]  <= dv_r_q[k-1];
      end
      dv_x_q <= dv_x_d;
      out_q  <= out_d;
    end
  end

endmodule

// ----- rtl/triangle_unit_normal_top.sv -----
// top level of the triangle unit normal block
// Takes one triangle per transaction and returns its unit normal in signed Q1.30, rounded
// to nearest and saturated, with a degenerate flag and a zero vector when the cross
// product vanishes. Fully pipelined: a new triangle is accepted every cycle while nothing stalls,
// and a result passes through 5 front stages, the queue, then squares, sum, 32 square-root
// stages, rounding, numerator set-up, 33 divider stages and the output register; the
// square-root and divider pipelines, one bit per stage, make up most of that depth. The
// front and back stall separately through a four-entry queue.
module triangle_unit_normal_top import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tri_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tri_out_t out_data_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  mid_t f_data, b_data;

  tun_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (f_valid),
    .q_ready_i  (f_ready),
    .q_data_o   (f_data)
  );

  tun_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  tun_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (b_valid),
    .q_ready_o   (b_ready),
    .q_data_i    (b_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/triangle_unit_normal_checker.sv -----
// checker for the triangle unit normal block: watches both channels, predicts and compares
`timescale 1ns / 1ps
module triangle_unit_normal_checker import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  tri_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  tri_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  tri_out_t normals_q[$];

  // exact integer square root, rounded to nearest
  function automatic logic [63:0] round_root(logic [63:0] x);
    logic [63:0] res, bitv, rem;
    res = 0;
    bitv = 64'd1 << 62;
    rem = x;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic tri_out_t unit_normal(tri_in_t t);
    logic signed [127:0] ax, ay, az, bx, by, bz;
    logic signed [127:0] n [3];
    logic [127:0] mag [3];
    logic [63:0] m [3];
    logic [127:0] big, q;
    logic [63:0] s, r;
    int len, sh;
    tri_out_t res;
    ax = t.p1_x - t.p0_x;
    ay = t.p1_y - t.p0_y;
    az = t.p1_z - t.p0_z;
    bx = t.p2_x - t.p0_x;
    by = t.p2_y - t.p0_y;
    bz = t.p2_z - t.p0_z;
    n[0] = ay * bz - az * by;
    n[1] = az * bx - ax * bz;
    n[2] = ax * by - ay * bx;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? -n[i] : n[i];
      if (mag[i] > big) big = mag[i];
    end
    res = '0;
    if (big == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    len = 0;
    while (big != 0) begin
      len++;
      big >>= 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (len <= 31) begin
        m[i] = 64'(mag[i] << (31 - len));
      end else begin
        sh = len - 31;
        m[i] = 64'((mag[i] >> sh) + ((mag[i] >> (sh - 1)) & 1));
      end
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = round_root(s);
    for (int i = 0; i < 3; i++) begin
      q = ((128'(m[i]) << NORM_FRAC) + (r >> 1)) / r;
      if (q > 128'(NORM_MAX)) q = 128'(NORM_MAX);
      if (n[i] < 0) q = -q;
      case (i)
        0: res.norm_x = q[NORM_WIDTH-1:0];
        1: res.norm_y = q[NORM_WIDTH-1:0];
        default: res.norm_z = q[NORM_WIDTH-1:0];
      endcase
    end
    return res;
  endfunction

  assign pending_o = normals_q.size();

  always @(posedge clk_i) begin
    tri_out_t exp_n;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) normals_q.push_back(unit_normal(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (normals_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_n = normals_q.pop_front();
          if (exp_n !== out_data_i) begin
            if (exp_n.norm_x !== out_data_i.norm_x)
              $error("norm_x expected %0d got %0d", exp_n.norm_x, out_data_i.norm_x);
            if (exp_n.norm_y !== out_data_i.norm_y)
              $error("norm_y expected %0d got %0d", exp_n.norm_y, out_data_i.norm_y);
            if (exp_n.norm_z !== out_data_i.norm_z)
              $error("norm_z expected %0d got %0d", exp_n.norm_z, out_data_i.norm_z);
            if (exp_n.degenerate !== out_data_i.degenerate)
              $error("degenerate expected %0b got %0b", exp_n.degenerate,
                     out_data_i.degenerate);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/triangle_unit_normal_top_test.sv -----
// testbench top for the triangle unit normal block: stimulus, idling and verdict
`timescale 1ns / 1ps
module triangle_unit_normal_top_test;
  import tun_pkg::*;

  localparam int LATENCY = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tri_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tri_out_t out_data;
  int       fail_count, pending;
  int       send_idle = 35, recv_idle = 64;
  bit       hold_off = 1'b0;
  int       cycles = 0;

  always #5 clk = ~clk;

  triangle_unit_normal_top i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  triangle_unit_normal_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_data_i(out_data), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  // valid stays up between back-to-back transactions and drops only while idling
  task automatic send_tri(tri_in_t t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic tri_in_t random_tri();
    tri_in_t t;
    int mode;
    logic [31:0] c [9];
    mode = $urandom_range(3);
    for (int i = 0; i < 9; i++) c[i] = rand_coord($urandom_range(9) == 0 ? 3 : mode);
    t = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    case ($urandom_range(9))
      0: t.p1_x = t.p0_x;
      1: begin t.p1_x = t.p0_x; t.p1_y = t.p0_y; t.p1_z = t.p0_z; end
      2: begin t.p2_x = t.p1_x; t.p2_y = t.p1_y; t.p2_z = t.p1_z; end
      default: ;
    endcase
    return t;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_tri(random_tri());
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    tri_in_t t;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: unit axes, winding, extremes and degenerate triangles
    t = '0; t.p1_x = 32'h1_0000; t.p2_y = 32'h1_0000;
    send_tri(t);
    t = '0; t.p1_y = 32'h1_0000; t.p2_x = 32'h1_0000;
    send_tri(t);
    t = '0; t.p1_y = 32'h1_0000; t.p2_z = 32'h1_0000;
    send_tri(t);
    t = '0; t.p1_z = 32'h1_0000; t.p2_x = 32'h1_0000;
    send_tri(t);
    send_tri('0);
    t = '0; t.p1_x = 32'h1_0000; t.p2_x = 32'h2_0000;
    send_tri(t);
    t = '0; t.p1_x = 1; t.p2_y = 1;
    send_tri(t);
    t = '0; t.p1_x = 1; t.p2_y = 1; t.p2_z = 1;
    send_tri(t);
    t = '0; t.p0_x = 32'h8000_0000; t.p0_y = 32'h8000_0000; t.p0_z = 32'h8000_0000;
    t.p1_x = 32'h7fff_ffff; t.p1_y = 32'h8000_0000; t.p1_z = 32'h8000_0000;
    t.p2_x = 32'h8000_0000; t.p2_y = 32'h7fff_ffff; t.p2_z = 32'h8000_0000;
    send_tri(t);
    t = {9{32'h7fff_ffff}}; t.p1_x = 32'h8000_0000; t.p2_y = 32'h8000_0000;
    t.p2_z = 32'h8000_0000;
    send_tri(t);
    t = {9{32'hffff_ffff}};
    send_tri(t);
    t = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    send_tri(t);
    t = '0; t.p1_x = 32'h3; t.p1_y = 32'h4; t.p2_z = 32'h5;
    send_tri(t);
    run_random(150);

    // sender pause until everything is back
    wait_drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      run_random(100);
    join

    send_idle = 64;
    recv_idle = 35;
    run_random(150);
    send_idle = 0;
    recv_idle = 0;
    run_random(100);

    wait_drain();
    repeat (LATENCY) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
